[hdl/knn_sel_pkg.sv]
package knn_sel_pkg;

  localparam int ID_BITS       = 32;
  localparam int DIST_OUT_BITS = 50;
  localparam int NCOUNT_BITS   = 5;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_X       = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Y       = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_CENTER_Z       = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_NEIGHBOR_COUNT = 2'd3;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_FLUSH,
    ST_DRAIN
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_NEW,
    OP_LEFT,
    OP_RIGHT
  } cell_op_e;

  typedef struct packed {
    logic insert;
    logic full;
    logic shift_out;
  } cell_ctrl_t;

endpackage

[hdl/knn_sel_pt_if.sv]
interface knn_sel_pt_if #(
  parameter int COORD_BITS = 24
);
  logic                                valid;
  logic                                ready;
  logic signed [COORD_BITS-1:0]        pt_x;
  logic signed [COORD_BITS-1:0]        pt_y;
  logic signed [COORD_BITS-1:0]        pt_z;
  logic [knn_sel_pkg::ID_BITS-1:0]     feature_id;
  logic [knn_sel_pkg::ID_BITS-1:0]     row_id;
  logic                                last_point;

  modport source (
    output valid, pt_x, pt_y, pt_z, feature_id, row_id, last_point,
    input  ready
  );

  modport sink (
    input  valid, pt_x, pt_y, pt_z, feature_id, row_id, last_point,
    output ready
  );
endinterface

[hdl/knn_sel_nb_if.sv]
interface knn_sel_nb_if #(
  parameter int COORD_BITS = 24
);
  logic                                  valid;
  logic                                  ready;
  logic [knn_sel_pkg::DIST_OUT_BITS-1:0] dist_sq;
  logic signed [COORD_BITS-1:0]          nb_x;
  logic signed [COORD_BITS-1:0]          nb_y;
  logic signed [COORD_BITS-1:0]          nb_z;
  logic [knn_sel_pkg::ID_BITS-1:0]       nb_feature;
  logic [knn_sel_pkg::ID_BITS-1:0]       nb_row;
  logic                                  last_result;

  modport source (
    output valid, dist_sq, nb_x, nb_y, nb_z, nb_feature, nb_row, last_result,
    input  ready
  );

  modport sink (
    input  valid, dist_sq, nb_x, nb_y, nb_z, nb_feature, nb_row, last_result,
    output ready
  );
endinterface

[hdl/knn_sel_dist.sv]
module knn_sel_dist #(
  parameter int COORD_BITS = 24,
  parameter int PAY_BITS   = 3 * 24 + 64,
  parameter int DIST_BITS  = 2 * 24 + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  vld_i,
  input  logic [PAY_BITS-1:0]   pay_i,
  input  logic                  last_i,
  input  logic [COORD_BITS-1:0] center_x_i,
  input  logic [COORD_BITS-1:0] center_y_i,
  input  logic [COORD_BITS-1:0] center_z_i,
  output logic                  vld_o,
  output logic [DIST_BITS-1:0]  dist_o,
  output logic [PAY_BITS-1:0]   pay_o,
  output logic                  last_o
);

  localparam int MAG_BITS = COORD_BITS + 1;
  localparam int XOFF     = 2 * knn_sel_pkg::ID_BITS + 2 * COORD_BITS;
  localparam int YOFF     = 2 * knn_sel_pkg::ID_BITS + COORD_BITS;
  localparam int ZOFF     = 2 * knn_sel_pkg::ID_BITS;

  logic signed [MAG_BITS-1:0] dx, dy, dz;
  logic [MAG_BITS-1:0]        mx_d, my_d, mz_d;
  logic [2*MAG_BITS-1:0]      sqx_d, sqy_d, sqz_d;

  logic                       vld1_q, vld2_q, vld3_q;
  logic                       last1_q, last2_q, last3_q;
  logic [PAY_BITS-1:0]        pay1_q, pay2_q, pay3_q;
  logic [MAG_BITS-1:0]        mx_q, my_q, mz_q;
  logic [DIST_BITS-1:0]       sx_q, sy_q, sz_q;
  logic [DIST_BITS-1:0]       dist_q;

  // Sign-extend by one bit so the difference cannot overflow.
  assign dx = $signed({pay_i[XOFF+COORD_BITS-1], pay_i[XOFF +: COORD_BITS]})
            - $signed({center_x_i[COORD_BITS-1], center_x_i});
  assign dy = $signed({pay_i[YOFF+COORD_BITS-1], pay_i[YOFF +: COORD_BITS]})
            - $signed({center_y_i[COORD_BITS-1], center_y_i});
  assign dz = $signed({pay_i[ZOFF+COORD_BITS-1], pay_i[ZOFF +: COORD_BITS]})
            - $signed({center_z_i[COORD_BITS-1], center_z_i});

  assign mx_d = dx[MAG_BITS-1] ? MAG_BITS'(-dx) : MAG_BITS'(dx);
  assign my_d = dy[MAG_BITS-1] ? MAG_BITS'(-dy) : MAG_BITS'(dy);
  assign mz_d = dz[MAG_BITS-1] ? MAG_BITS'(-dz) : MAG_BITS'(dz);

  // Full-width products of the magnitudes.
  assign sqx_d = mx_q * mx_q;
  assign sqy_d = my_q * my_q;
  assign sqz_d = mz_q * mz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
    end else begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= mx_d;
    my_q    <= my_d;
    mz_q    <= mz_d;
    pay1_q  <= pay_i;
    last1_q <= last_i;

    sx_q    <= DIST_BITS'(sqx_d);
    sy_q    <= DIST_BITS'(sqy_d);
    sz_q    <= DIST_BITS'(sqz_d);
    pay2_q  <= pay1_q;
    last2_q <= last1_q;

    dist_q  <= sx_q + sy_q + sz_q;
    pay3_q  <= pay2_q;
    last3_q <= last2_q;
  end

  assign vld_o  = vld3_q;
  assign dist_o = dist_q;
  assign pay_o  = pay3_q;
  assign last_o = last3_q;

endmodule

[hdl/knn_sel_cell.sv]
module knn_sel_cell #(
  parameter int DIST_BITS = 2 * 24 + 2,
  parameter int PAY_BITS  = 3 * 24 + 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  knn_sel_pkg::cell_ctrl_t ctrl_i,
  input  logic [DIST_BITS-1:0]    new_dist_i,
  input  logic [PAY_BITS-1:0]     new_pay_i,
  input  logic                    left_le_i,
  input  logic                    left_vld_i,
  input  logic [DIST_BITS-1:0]    left_dist_i,
  input  logic [PAY_BITS-1:0]     left_pay_i,
  input  logic                    right_vld_i,
  input  logic [DIST_BITS-1:0]    right_dist_i,
  input  logic [PAY_BITS-1:0]     right_pay_i,
  output logic                    le_o,
  output logic                    vld_o,
  output logic [DIST_BITS-1:0]    dist_o,
  output logic [PAY_BITS-1:0]     pay_o
);

  logic                  vld_q;
  logic [DIST_BITS-1:0]  dist_q;
  logic [PAY_BITS-1:0]   pay_q;
  knn_sel_pkg::cell_op_e op;

  // A held entry at or below the new distance stays in front of it.
  assign le_o = vld_q && (dist_q <= new_dist_i);

  always_comb begin
    op = knn_sel_pkg::OP_HOLD;
    if (ctrl_i.shift_out) begin
      op = knn_sel_pkg::OP_RIGHT;
    end else if (ctrl_i.insert) begin
      if (le_o) begin
        op = knn_sel_pkg::OP_HOLD;
      end else if (ctrl_i.full && !vld_q) begin
        // A full table never grows; the tail entry falls off instead.
        op = knn_sel_pkg::OP_HOLD;
      end else if (left_le_i) begin
        op = knn_sel_pkg::OP_NEW;
      end else begin
        op = knn_sel_pkg::OP_LEFT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      case (op)
        knn_sel_pkg::OP_NEW:   vld_q <= 1'b1;
        knn_sel_pkg::OP_LEFT:  vld_q <= left_vld_i;
        knn_sel_pkg::OP_RIGHT: vld_q <= right_vld_i;
        default:               vld_q <= vld_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op)
      knn_sel_pkg::OP_NEW: begin
        dist_q <= new_dist_i;
        pay_q  <= new_pay_i;
      end
      knn_sel_pkg::OP_LEFT: begin
        dist_q <= left_dist_i;
        pay_q  <= left_pay_i;
      end
      knn_sel_pkg::OP_RIGHT: begin
        dist_q <= right_dist_i;
        pay_q  <= right_pay_i;
      end
      default: begin
        dist_q <= dist_q;
        pay_q  <= pay_q;
      end
    endcase
  end

  assign vld_o  = vld_q;
  assign dist_o = dist_q;
  assign pay_o  = pay_q;

endmodule

[hdl/knn_top_k_selector.sv]
// Channel   Role    Item                                    Handshake
// pt_in     sink    point: coordinates, ids, last flag      valid/ready
// nb_out    source  neighbor: distance, coordinates, ids    valid/ready
// cfg       write   centre x/y/z, neighbor count            cfg_we_i, no ready
//
// A point is taken every cycle while a query is running. Its distance comes
// out of a three-stage difference/square/sum pipeline and is then inserted
// into the sorted row of MAX_NEIGHBORS cells.
// After the last point is taken, input stays blocked until readout ends. Once
// the pipeline has emptied, the row shifts out one neighbor per cycle into
// the output register, except while nb_out stalls.
// Reset clears the cell valid bits, the fill count and the centre, and sets the neighbor count to one.
module knn_top_k_selector #(
  parameter int MAX_NEIGHBORS = 16,
  parameter int COORD_BITS    = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  knn_sel_pt_if.sink                            pt_in,
  knn_sel_nb_if.source                          nb_out,
  input  logic                                  cfg_we_i,
  input  logic [knn_sel_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [COORD_BITS-1:0]                 cfg_data_i
);

  localparam int ID_BITS   = knn_sel_pkg::ID_BITS;
  localparam int PAY_BITS  = 3 * COORD_BITS + 2 * ID_BITS;
  localparam int DIST_BITS = 2 * COORD_BITS + 2;
  localparam int CNT_BITS  = $clog2(MAX_NEIGHBORS + 1);
  localparam int KW        = (CNT_BITS > knn_sel_pkg::NCOUNT_BITS) ?
                             CNT_BITS : knn_sel_pkg::NCOUNT_BITS;
  localparam int XOFF      = 2 * ID_BITS + 2 * COORD_BITS;
  localparam int YOFF      = 2 * ID_BITS + COORD_BITS;
  localparam int ZOFF      = 2 * ID_BITS;

  // Configuration registers.
  logic [COORD_BITS-1:0]               center_x_q, center_y_q, center_z_q;
  logic [knn_sel_pkg::NCOUNT_BITS-1:0] ncount_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= '0;
      center_y_q <= '0;
      center_z_q <= '0;
      ncount_q   <= knn_sel_pkg::NCOUNT_BITS'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        knn_sel_pkg::CFG_CENTER_X:       center_x_q <= cfg_data_i;
        knn_sel_pkg::CFG_CENTER_Y:       center_y_q <= cfg_data_i;
        knn_sel_pkg::CFG_CENTER_Z:       center_z_q <= cfg_data_i;
        knn_sel_pkg::CFG_NEIGHBOR_COUNT:
          ncount_q <= cfg_data_i[knn_sel_pkg::NCOUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Distance pipeline.
  logic                 in_acc;
  logic [PAY_BITS-1:0]  in_pay;
  logic                 ins_vld, ins_last;
  logic [DIST_BITS-1:0] ins_dist;
  logic [PAY_BITS-1:0]  ins_pay;

  assign in_acc = pt_in.valid && pt_in.ready;
  assign in_pay = {pt_in.pt_x, pt_in.pt_y, pt_in.pt_z, pt_in.feature_id, pt_in.row_id};

  knn_sel_dist #(
    .COORD_BITS (COORD_BITS),
    .PAY_BITS   (PAY_BITS),
    .DIST_BITS  (DIST_BITS)
  ) u_dist (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .vld_i      (in_acc),
    .pay_i      (in_pay),
    .last_i     (pt_in.last_point),
    .center_x_i (center_x_q),
    .center_y_i (center_y_q),
    .center_z_i (center_z_q),
    .vld_o      (ins_vld),
    .dist_o     (ins_dist),
    .pay_o      (ins_pay),
    .last_o     (ins_last)
  );

  // Control.
  knn_sel_pkg::state_e state_q, state_d;
  logic [CNT_BITS-1:0] count_q;
  logic [KW-1:0]       keep_lim;
  logic                full;
  logic                out_free;
  logic                shift_out;
  logic                in_ready;

  always_comb begin
    keep_lim = KW'(ncount_q);
    if (ncount_q == '0) begin
      keep_lim = KW'(1);
    end else if (keep_lim > KW'(MAX_NEIGHBORS)) begin
      keep_lim = KW'(MAX_NEIGHBORS);
    end
  end

  assign full     = KW'(count_q) >= keep_lim;
  assign out_free = !nb_out.valid || nb_out.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      knn_sel_pkg::ST_FILL: begin
        if (in_acc && pt_in.last_point) state_d = knn_sel_pkg::ST_FLUSH;
      end
      knn_sel_pkg::ST_FLUSH: begin
        if (ins_vld && ins_last) state_d = knn_sel_pkg::ST_DRAIN;
      end
      knn_sel_pkg::ST_DRAIN: begin
        if (shift_out && count_q == CNT_BITS'(1)) state_d = knn_sel_pkg::ST_FILL;
      end
      default: state_d = knn_sel_pkg::ST_FILL;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    shift_out = 1'b0;
    case (state_q)
      knn_sel_pkg::ST_FILL:  in_ready  = 1'b1;
      knn_sel_pkg::ST_DRAIN: shift_out = out_free;
      default: ;
    endcase
  end

  assign pt_in.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= knn_sel_pkg::ST_FILL;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      if (shift_out) begin
        count_q <= count_q - CNT_BITS'(1);
      end else if (ins_vld && !full) begin
        count_q <= count_q + CNT_BITS'(1);
      end
    end
  end

  // Sorted row of cells, nearest in cell 0.
  knn_sel_pkg::cell_ctrl_t ctrl;
  logic [MAX_NEIGHBORS:0]   le_chain;
  logic [MAX_NEIGHBORS-1:0] vld_vec;
  logic [DIST_BITS-1:0]     cell_dist [MAX_NEIGHBORS];
  logic [PAY_BITS-1:0]      cell_pay  [MAX_NEIGHBORS];

  assign ctrl.insert    = ins_vld;
  assign ctrl.full      = full;
  assign ctrl.shift_out = shift_out;
  assign le_chain[0]    = 1'b1;

  for (genvar i = 0; i < MAX_NEIGHBORS; i++) begin : g_cell
    logic                 lvld, rvld;
    logic [DIST_BITS-1:0] ldist, rdist;
    logic [PAY_BITS-1:0]  lpay, rpay;

    if (i == 0) begin : g_head
      assign lvld  = 1'b0;
      assign ldist = '0;
      assign lpay  = '0;
    end else begin : g_mid
      assign lvld  = vld_vec[i-1];
      assign ldist = cell_dist[i-1];
      assign lpay  = cell_pay[i-1];
    end

    if (i == MAX_NEIGHBORS - 1) begin : g_tail
      assign rvld  = 1'b0;
      assign rdist = '0;
      assign rpay  = '0;
    end else begin : g_body
      assign rvld  = vld_vec[i+1];
      assign rdist = cell_dist[i+1];
      assign rpay  = cell_pay[i+1];
    end

    knn_sel_cell #(
      .DIST_BITS (DIST_BITS),
      .PAY_BITS  (PAY_BITS)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .new_dist_i   (ins_dist),
      .new_pay_i    (ins_pay),
      .left_le_i    (le_chain[i]),
      .left_vld_i   (lvld),
      .left_dist_i  (ldist),
      .left_pay_i   (lpay),
      .right_vld_i  (rvld),
      .right_dist_i (rdist),
      .right_pay_i  (rpay),
      .le_o         (le_chain[i+1]),
      .vld_o        (vld_vec[i]),
      .dist_o       (cell_dist[i]),
      .pay_o        (cell_pay[i])
    );
  end

  // Output register.
  logic                                  out_vld_q;
  logic [knn_sel_pkg::DIST_OUT_BITS-1:0] out_dist_q;
  logic [PAY_BITS-1:0]                   out_pay_q;
  logic                                  out_last_q;
  logic [63:0]                           head_dist;

  assign head_dist = 64'(cell_dist[0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (shift_out) begin
      out_vld_q <= 1'b1;
    end else if (nb_out.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (shift_out) begin
      out_dist_q <= head_dist[knn_sel_pkg::DIST_OUT_BITS-1:0];
      out_pay_q  <= cell_pay[0];
      out_last_q <= (count_q == CNT_BITS'(1));
    end
  end

  assign nb_out.valid       = out_vld_q;
  assign nb_out.dist_sq     = out_dist_q;
  assign nb_out.nb_x        = out_pay_q[XOFF +: COORD_BITS];
  assign nb_out.nb_y        = out_pay_q[YOFF +: COORD_BITS];
  assign nb_out.nb_z        = out_pay_q[ZOFF +: COORD_BITS];
  assign nb_out.nb_feature  = out_pay_q[ID_BITS +: ID_BITS];
  assign nb_out.nb_row      = out_pay_q[ID_BITS-1:0];
  assign nb_out.last_result = out_last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(count_q) <= MAX_NEIGHBORS)
    else $error("fill count exceeds the number of cells");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(vld_vec) == int'(count_q))
    else $error("cell valid bits disagree with the fill count");

  a_no_insert_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == knn_sel_pkg::ST_DRAIN |-> !ins_vld)
    else $error("item reached the cells during readout");

  a_last_marker: assert property (@(posedge clk_i) disable iff (!rst_ni)
    shift_out && count_q == CNT_BITS'(1) |=> nb_out.valid && nb_out.last_result
      && state_q == knn_sel_pkg::ST_FILL)
    else $error("readout end not marked on the final neighbor");

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == knn_sel_pkg::ST_DRAIN |-> count_q != '0)
    else $error("readout with an empty cell row");
`endif

endmodule
